// ===== rtl/core/dnle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants of the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

    localparam logic [7:0] DOT_CHAR    = 8'h2E;
    localparam int         QUEUE_DEPTH = 4;
    localparam int         QUEUE_AW    = 2;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_char;
        logic       is_dot;
        logic       is_end;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/dnle_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dnle_in_if
// Character channel of the encoder: one name character per transaction.
// ----------------------------------------------------------------------------
interface dnle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       has_char;
    logic       name_end;

    modport source (output valid, output ch, output has_char, output name_end, input ready);
    modport sink   (input valid, input ch, input has_char, input name_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dnle_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dnle_out_if
// Byte channel of the encoder: one wire-format byte per transaction.
// ----------------------------------------------------------------------------
interface dnle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       name_done;
    logic       overflow;

    modport source (output valid, output out_byte, output run_last, output name_done,
                    output overflow, input ready);
    modport sink   (input valid, input out_byte, input run_last, input name_done,
                    input overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dnle_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dnle_front
// Accepts character transactions and classifies them into commands.
// ----------------------------------------------------------------------------
module dnle_front (
    dnle_in_if.sink          in_ch,
    input  wire logic        full,
    output logic             push,
    output dnle_pkg::cmd_t   push_cmd
);

    logic is_dot_char;

    assign is_dot_char      = (in_ch.ch == dnle_pkg::DOT_CHAR);
    assign in_ch.ready      = !full;

    assign push_cmd.ch      = in_ch.ch;
    assign push_cmd.is_char = in_ch.has_char && !is_dot_char;
    assign push_cmd.is_dot  = in_ch.has_char && is_dot_char;
    assign push_cmd.is_end  = in_ch.name_end;

    // idle transactions change nothing and are dropped here
    assign push = in_ch.valid && !full && (in_ch.has_char || in_ch.name_end);

endmodule
`default_nettype wire

// ===== rtl/core/dnle_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dnle_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module dnle_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dnle_pkg::cmd_t  push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output dnle_pkg::cmd_t       head,
    output logic                 empty
);

    localparam int CW = dnle_pkg::QUEUE_AW + 1;

    dnle_pkg::cmd_t                  slot_reg [dnle_pkg::QUEUE_DEPTH];
    logic [dnle_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dnle_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                   fill_reg, fill_next;
    logic                            do_push, do_pop;

    assign full    = (fill_reg == CW'(dnle_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dnle_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dnle_back
// Executes commands: buffers label characters, emits length, label bytes and
// the terminating zero through an output register.
// ----------------------------------------------------------------------------
module dnle_back #(
    parameter int LABEL_MAX = 62
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dnle_pkg::cmd_t  head,
    input  wire logic            empty,
    output logic                 pop,
    dnle_out_if.source           out_ch
);

    localparam int CNT_W  = $clog2(LABEL_MAX + 1);
    localparam int ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LEN  = 4'b0010,
        S_DATA = 4'b0100,
        S_ZERO = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic               ovf_reg, ovf_next;
    logic               end_pend_reg, end_pend_next;

    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               run_last_reg, run_last_next;
    logic               name_done_reg, name_done_next;
    logic               overflow_reg, overflow_next;

    logic [7:0]         label_mem [LABEL_MAX];
    logic [7:0]         rd_data_reg;
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  rd_addr;

    logic               free;
    logic               store_ok;
    logic [CNT_W-1:0]   count_eff;
    logic [CNT_W-1:0]   idx_plus;
    logic               last_data;

    assign free      = !out_valid_reg || out_ch.ready;
    assign pop       = (state_reg == S_IDLE) && !empty;
    assign store_ok  = head.is_char && (count_reg < CNT_W'(LABEL_MAX));
    assign wr_en     = pop && store_ok;
    assign count_eff = store_ok ? count_reg + 1'b1 : count_reg;
    assign idx_plus  = CNT_W'(idx_reg) + 1'b1;
    assign last_data = (idx_plus == len_reg);
    assign rd_addr   = (state_reg == S_LEN) ? '0 : idx_plus[ADDR_W-1:0];

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.run_last  = run_last_reg;
    assign out_ch.name_done = name_done_reg;
    assign out_ch.overflow  = overflow_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        ovf_next       = ovf_reg;
        end_pend_next  = end_pend_reg;
        out_valid_next = out_ch.ready ? 1'b0 : out_valid_reg;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        name_done_next = name_done_reg;
        overflow_next  = overflow_reg;
        rd_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    if (head.is_char && !store_ok)
                    begin
                        ovf_next = 1'b1;
                    end
                    if ((head.is_dot || head.is_end) && (count_eff != '0))
                    begin
                        len_next      = count_eff;
                        count_next    = '0;
                        end_pend_next = head.is_end;
                        state_next    = S_LEN;
                    end
                    else if (head.is_end)
                    begin
                        count_next = '0;
                        state_next = S_ZERO;
                    end
                    else
                    begin
                        count_next = count_eff;
                    end
                end
            end
            S_LEN:
            begin
                if (free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'(len_reg);
                    run_last_next  = 1'b0;
                    name_done_next = 1'b0;
                    overflow_next  = ovf_reg;
                    rd_en          = 1'b1;
                    idx_next       = '0;
                    state_next     = S_DATA;
                end
            end
            S_DATA:
            begin
                if (free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data_reg;
                    run_last_next  = last_data && !end_pend_reg;
                    name_done_next = 1'b0;
                    overflow_next  = ovf_reg;
                    if (last_data)
                    begin
                        state_next = end_pend_reg ? S_ZERO : S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_plus[ADDR_W-1:0];
                    end
                end
            end
            S_ZERO:
            begin
                if (free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'h00;
                    run_last_next  = 1'b1;
                    name_done_next = 1'b1;
                    overflow_next  = ovf_reg;
                    ovf_next       = 1'b0;
                    end_pend_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            end_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            end_pend_reg  <= end_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        out_byte_reg  <= out_byte_next;
        run_last_reg  <= run_last_next;
        name_done_reg <= name_done_next;
        overflow_reg  <= overflow_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            label_mem[count_reg[ADDR_W-1:0]] <= head.ch;
        end
        if (rd_en)
        begin
            rd_data_reg <= label_mem[rd_addr];
        end
    end

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && name_done_reg |-> run_last_reg && (out_byte_reg == 8'h00))
        else $error("zero byte without run_last");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LABEL_MAX))
        else $error("label count beyond limit");

    a_idx_in_label: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) |-> (CNT_W'(idx_reg) < len_reg))
        else $error("label index past label length");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEN) |-> (count_reg == '0) && (len_reg != '0))
        else $error("flush entered with bad counters");

    a_done_resets_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ZERO) && free |=> !ovf_reg)
        else $error("overflow flag survived end of name");

endmodule
`default_nettype wire

// ===== rtl/core/dns_name_label_encoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dns_name_label_encoder_core
// Dotted domain name to DNS wire form encoder, one character in, one byte out.
// ----------------------------------------------------------------------------
//  channel  dir  transaction      payload
//  in_ch    in   one character    ch, has_char, name_end
//  out_ch   out  one wire byte    out_byte, run_last, name_done, overflow
//
//  A label character is buffered in the back end; a dot or end flushes the label
//  as its length byte and label bytes, and an end then adds the zero byte.
//  The front accepts while the 4-entry command queue has room.
//  Output bytes leave through an output register; out_ch stalls hold the back.
//  rst_n clears queue, label counter and overflow flag; label store is not cleared.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_core #(
    parameter int LABEL_MAX = 62
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    dnle_in_if.sink      in_ch,
    dnle_out_if.source   out_ch
);

    logic            push, full, pop, empty;
    dnle_pkg::cmd_t  push_cmd, head;

    dnle_front u_front (
        .in_ch    (in_ch),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    dnle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    dnle_back #(
        .LABEL_MAX (LABEL_MAX)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule
`default_nettype wire
